/* design/tlf_pkg.sv */
package tlf_pkg;

   // Field widths
   localparam int VALUE_W = 16;
   localparam int CODE_W  = 8;
   localparam int MAG_W   = 14;
   localparam int FULL_W  = 17;
   localparam int PROD_W  = 27;
   localparam int Q10_W   = 10;
   localparam int Q100_W  = 7;
   localparam int DIGIT_W = 4;
   localparam int IDX_W   = 4;
   localparam int LEAD_W  = 2;

   // Character and command codes
   localparam logic [CODE_W-1:0] CH_MINUS      = 8'h2D;
   localparam logic [CODE_W-1:0] CH_BLANK      = 8'hA0;
   localparam logic [CODE_W-1:0] CH_POINT      = 8'h2E;
   localparam logic [CODE_W-1:0] CH_DEGREE     = 8'hDF;
   localparam logic [CODE_W-1:0] CH_C          = 8'h43;
   localparam logic [CODE_W-1:0] CH_ZERO       = 8'h30;
   localparam logic [CODE_W-1:0] POS_CMD_RESET = 8'h80;

   // Magnitude limit and reciprocal constants (exact for magnitudes below the limit)
   localparam logic [FULL_W-1:0] MAG_LIMIT  = 17'd10000;
   localparam logic [FULL_W-1:0] FULL_RANGE = 17'h10000;
   localparam logic [PROD_W-1:0] RECIP_100  = 27'd5243;
   localparam int                RECIP_100_SHIFT = 19;
   localparam logic [PROD_W-1:0] RECIP_10   = 27'd6554;
   localparam int                RECIP_10_SHIFT  = 16;

   // Byte positions in a run
   localparam logic [IDX_W-1:0] BYTE_CMD   = 4'd0;
   localparam logic [IDX_W-1:0] BYTE_SIGN  = 4'd1;
   localparam logic [IDX_W-1:0] BYTE_FIRST = 4'd2;
   localparam logic [IDX_W-1:0] LAST_BIG   = 4'd1;
   localparam logic [IDX_W-1:0] LAST_SHORT = 4'd8;
   localparam logic [IDX_W-1:0] LAST_LONG  = 4'd9;

   // Slots of the number field once leading positions are skipped
   localparam logic [IDX_W-1:0] SLOT_THOUSANDS = 4'd0;
   localparam logic [IDX_W-1:0] SLOT_HUNDREDS  = 4'd1;
   localparam logic [IDX_W-1:0] SLOT_TENS      = 4'd2;
   localparam logic [IDX_W-1:0] SLOT_POINT     = 4'd3;
   localparam logic [IDX_W-1:0] SLOT_FRACTION  = 4'd4;
   localparam logic [IDX_W-1:0] SLOT_UNIT_HI   = 4'd5;
   localparam logic [IDX_W-1:0] SLOT_UNIT_LO   = 4'd6;

   // Leading positions skipped: none (four digits), one, two
   localparam logic [LEAD_W-1:0] LEAD_NONE = 2'd0;
   localparam logic [LEAD_W-1:0] LEAD_ONE  = 2'd1;
   localparam logic [LEAD_W-1:0] LEAD_TWO  = 2'd2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                neg;
      logic                celsius;
      logic                big;
      logic [LEAD_W-1:0]   lead;
      logic [DIGIT_W-1:0]  d_th;
      logic [DIGIT_W-1:0]  d_hu;
      logic [DIGIT_W-1:0]  d_te;
      logic [DIGIT_W-1:0]  d_fr;
   } tlf_item_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] ones;
   } tlf_bcd2_type;

   // Split a value below 100 into two decimal digits (nine parallel compares)
   function automatic tlf_bcd2_type tlf_split_tens(input logic [Q100_W-1:0] value);
      tlf_bcd2_type      res;
      logic [Q100_W-1:0] rest;
      res.tens = '0;
      for (int i = 1; i < 10; i++) begin
         if (value >= Q100_W'(i * 10)) begin
            res.tens = DIGIT_W'(i);
         end
      end
      rest     = value - Q100_W'(res.tens) * Q100_W'(10);
      res.ones = rest[DIGIT_W-1:0];
      return res;
   endfunction

endpackage

/* design/tlf_if.sv */
interface tlf_req_if import tlf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  tenths_value;
   logic                       celsius_unit;

   modport source (output valid, tenths_value, celsius_unit, input ready);
   modport sink   (input valid, tenths_value, celsius_unit, output ready);
endinterface

interface tlf_rsp_if import tlf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] char_code;
   logic              is_command;
   logic              last;

   modport source (output valid, char_code, is_command, last, input ready);
   modport sink   (input valid, char_code, is_command, last, output ready);
endinterface

interface tlf_csr_if import tlf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] position_command;

   modport source (output valid, position_command, input ready);
   modport sink   (input valid, position_command, output ready);
endinterface

/* design/tlf_front.sv */
module tlf_front import tlf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tlf_req_if.sink      req_ch,
   output logic         push_valid,
   output tlf_item_type push_item,
   input  logic         queue_full
);

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_neg_ff, s1_neg_in;
   logic                s1_celsius_ff, s1_celsius_in;
   logic                s1_big_ff, s1_big_in;
   logic [MAG_W-1:0]    s1_mag_ff, s1_mag_in;

   logic                s2_valid_ff, s2_valid_in;
   logic                s2_neg_ff, s2_neg_in;
   logic                s2_celsius_ff, s2_celsius_in;
   logic                s2_big_ff, s2_big_in;
   logic [MAG_W-1:0]    s2_mag_ff, s2_mag_in;
   logic [Q10_W-1:0]    s2_q10_ff, s2_q10_in;
   logic [Q100_W-1:0]   s2_q100_ff, s2_q100_in;

   logic                accept;
   logic                s2_free;
   logic                s1_move;
   logic [VALUE_W-1:0]  raw;
   logic                raw_neg;
   logic [FULL_W-1:0]   mag_full;
   logic [PROD_W-1:0]   prod100;
   logic [PROD_W-1:0]   prod10;
   logic [MAG_W-1:0]    frac_wide;
   logic [Q10_W-1:0]    tens_wide;
   tlf_bcd2_type        upper;

   // Advance the two stages when the queue has room
   assign push_valid   = s2_valid_ff && !queue_full;
   assign s2_free      = !s2_valid_ff || push_valid;
   assign s1_move      = s1_valid_ff && s2_free;
   assign req_ch.ready = !s1_valid_ff || s2_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // Take the magnitude and flag large values
   assign raw      = req_ch.tenths_value;
   assign raw_neg  = raw[VALUE_W-1];
   assign mag_full = raw_neg ? (FULL_RANGE - FULL_W'(raw)) : FULL_W'(raw);

   always_comb begin
      s1_valid_in   = accept || (s1_valid_ff && !s2_free);
      s1_neg_in     = s1_neg_ff;
      s1_celsius_in = s1_celsius_ff;
      s1_big_in     = s1_big_ff;
      s1_mag_in     = s1_mag_ff;
      if (accept) begin
         s1_neg_in     = raw_neg;
         s1_celsius_in = req_ch.celsius_unit;
         s1_big_in     = mag_full >= MAG_LIMIT;
         s1_mag_in     = mag_full[MAG_W-1:0];
      end
   end

   // Divide by 100 and by 10 through reciprocal products
   assign prod100 = PROD_W'(s1_mag_ff) * RECIP_100;
   assign prod10  = PROD_W'(s1_mag_ff) * RECIP_10;

   always_comb begin
      s2_valid_in   = s1_move || (s2_valid_ff && !push_valid);
      s2_neg_in     = s2_neg_ff;
      s2_celsius_in = s2_celsius_ff;
      s2_big_in     = s2_big_ff;
      s2_mag_in     = s2_mag_ff;
      s2_q10_in     = s2_q10_ff;
      s2_q100_in    = s2_q100_ff;
      if (s1_move) begin
         s2_neg_in     = s1_neg_ff;
         s2_celsius_in = s1_celsius_ff;
         s2_big_in     = s1_big_ff;
         s2_mag_in     = s1_mag_ff;
         s2_q10_in     = prod10[RECIP_10_SHIFT +: Q10_W];
         s2_q100_in    = prod100[RECIP_100_SHIFT +: Q100_W];
      end
   end

   // Build the digits and count the leading positions to skip
   assign frac_wide = s2_mag_ff - MAG_W'(s2_q10_ff) * MAG_W'(10);
   assign tens_wide = s2_q10_ff - Q10_W'(s2_q100_ff) * Q10_W'(10);
   assign upper     = tlf_split_tens(s2_q100_ff);

   always_comb begin
      push_item.neg     = s2_neg_ff;
      push_item.celsius = s2_celsius_ff;
      push_item.big     = s2_big_ff;
      push_item.d_th    = upper.tens;
      push_item.d_hu    = upper.ones;
      push_item.d_te    = tens_wide[DIGIT_W-1:0];
      push_item.d_fr    = frac_wide[DIGIT_W-1:0];
      if (s2_q100_ff >= Q100_W'(10)) begin
         push_item.lead = LEAD_NONE;
      end else if (s2_q100_ff != '0) begin
         push_item.lead = LEAD_ONE;
      end else begin
         push_item.lead = LEAD_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_neg_ff     <= s1_neg_in;
      s1_celsius_ff <= s1_celsius_in;
      s1_big_ff     <= s1_big_in;
      s1_mag_ff     <= s1_mag_in;
      s2_neg_ff     <= s2_neg_in;
      s2_celsius_ff <= s2_celsius_in;
      s2_big_ff     <= s2_big_in;
      s2_mag_ff     <= s2_mag_in;
      s2_q10_ff     <= s2_q10_in;
      s2_q100_ff    <= s2_q100_in;
   end

endmodule

/* design/tlf_queue.sv */
module tlf_queue import tlf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  tlf_item_type push_item,
   output logic         queue_full,
   output logic         head_valid,
   output tlf_item_type head_item,
   input  logic         pop
);

   tlf_item_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   assign queue_full = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = entries_ff[rd_ptr_ff];

   // Advance pointers and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill level above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("push into full queue");

endmodule

/* design/tlf_back.sv */
module tlf_back import tlf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tlf_csr_if.sink      csr_ch,
   tlf_rsp_if.source    rsp_ch,
   input  logic         head_valid,
   input  tlf_item_type head_item,
   output logic         pop
);

   logic [CODE_W-1:0] position_ff, position_in;
   logic [IDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] char_code_ff, char_code_in;
   logic              is_command_ff, is_command_in;
   logic              last_ff, last_in;

   logic              byte_load;
   logic              byte_last;
   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  slot;
   logic [CODE_W-1:0] byte_code;
   logic              byte_cmd;

   // Hold the cursor position command
   assign csr_ch.ready = 1'b1;
   assign position_in  = csr_ch.valid ? csr_ch.position_command : position_ff;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.char_code  = char_code_ff;
   assign rsp_ch.is_command = is_command_ff;
   assign rsp_ch.last       = last_ff;

   // Load the output register when an item waits and the register is empty or being taken
   assign byte_load = head_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      if (head_item.big) begin
         last_idx = LAST_BIG;
      end else if (head_item.lead == LEAD_NONE) begin
         last_idx = LAST_LONG;
      end else begin
         last_idx = LAST_SHORT;
      end
   end

   assign byte_last = byte_idx_ff == last_idx;
   assign pop       = byte_load && byte_last;
   assign slot      = byte_idx_ff - BYTE_FIRST + IDX_W'(head_item.lead);

   // Pick the byte for the current position
   always_comb begin
      byte_cmd = 1'b0;
      case (byte_idx_ff)
         BYTE_CMD: begin
            byte_code = position_ff;
            byte_cmd  = 1'b1;
         end
         BYTE_SIGN: begin
            byte_code = head_item.neg ? CH_MINUS : CH_BLANK;
         end
         default: begin
            case (slot)
               SLOT_THOUSANDS: byte_code = CH_ZERO + CODE_W'(head_item.d_th);
               SLOT_HUNDREDS:  byte_code = CH_ZERO + CODE_W'(head_item.d_hu);
               SLOT_TENS:      byte_code = CH_ZERO + CODE_W'(head_item.d_te);
               SLOT_POINT:     byte_code = CH_POINT;
               SLOT_FRACTION:  byte_code = CH_ZERO + CODE_W'(head_item.d_fr);
               SLOT_UNIT_HI:   byte_code = head_item.celsius ? CH_DEGREE : CH_BLANK;
               SLOT_UNIT_LO:   byte_code = head_item.celsius ? CH_C : CH_BLANK;
               default:        byte_code = CH_BLANK;
            endcase
         end
      endcase
   end

   // Advance the byte counter and the output word
   always_comb begin
      byte_idx_in   = byte_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      char_code_in  = char_code_ff;
      is_command_in = is_command_ff;
      last_in       = last_ff;
      if (byte_load) begin
         byte_idx_in   = byte_last ? BYTE_CMD : byte_idx_ff + 1'b1;
         rsp_valid_in  = 1'b1;
         char_code_in  = byte_code;
         is_command_in = byte_cmd;
         last_in       = byte_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= POS_CMD_RESET;
         byte_idx_ff  <= BYTE_CMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         byte_idx_ff  <= byte_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_code_ff  <= char_code_in;
      is_command_ff <= is_command_in;
      last_ff       <= last_in;
   end

   a_cmd_first: assert property (@(posedge clock) disable iff (reset)
      byte_load && (byte_idx_ff == BYTE_CMD) |=> is_command_ff && rsp_valid_ff)
      else $error("run does not open with the command byte");

   a_mid_run_item: assert property (@(posedge clock) disable iff (reset)
      (byte_idx_ff != BYTE_CMD) |-> head_valid)
      else $error("item left the queue in the middle of its run");

endmodule

/* design/tenths_value_to_lcd_field.sv */
// Formats a signed value in tenths as an 8- or 9-character LCD field.
// req_ch carries one word per item: tenths_value (signed, value x10) and
// celsius_unit. rsp_ch returns one LCD byte per word: first the cursor
// command (is_command high), then sign, digits with one fraction digit,
// the unit pair or two blanks, and trailing blanks; last marks the final
// byte. Magnitudes of 10000 or more give only the command and sign.
// csr_ch writes the cursor command byte; write it only while idle.
// Throughput: one byte per cycle on rsp_ch while rsp_ch is ready; an item
// is 9 or 10 bytes (2 for a large magnitude), as the byte sequencer in the
// back end sets. A two-stage front end computes the digits and a
// two-word queue lets the next item be formatted while bytes are sent.
// Reset clears the pipeline, the queue and the byte counter and loads the
// command byte 0x80. When rsp_ch stalls the current byte holds; the queue
// and the front stages fill and then req_ch.ready drops.
module tenths_value_to_lcd_field import tlf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tlf_req_if.sink   req_ch,
   tlf_rsp_if.source rsp_ch,
   tlf_csr_if.sink   csr_ch
);

   logic         push_valid;
   tlf_item_type push_item;
   logic         queue_full;
   logic         head_valid;
   tlf_item_type head_item;
   logic         pop;

   // Accept and convert to digits
   tlf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   // Decouple digit conversion from byte output
   tlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   // Emit the byte run
   tlf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .rsp_ch     (rsp_ch),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

endmodule

/* sim/lcd_field_checker.sv */
module lcd_field_checker import tlf_pkg::*; (
   input  logic clock,
   input  logic reset,
   tlf_req_if   req_ch,
   tlf_rsp_if   rsp_ch,
   tlf_csr_if   csr_ch,
   output int   mismatch_total,
   output int   bytes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LARGE_MAG = 10000;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              cmd;
      logic              last;
   } lcd_byte_type;

   lcd_byte_type      field_bytes_q [$];
   logic [CODE_W-1:0] cursor_cmd = POS_CMD_RESET;
   int                errors     = 0;

   function automatic void push_byte(input logic [CODE_W-1:0] code, input logic cmd);
      lcd_byte_type b;
      b.code = code;
      b.cmd  = cmd;
      b.last = 1'b0;
      field_bytes_q.push_back(b);
   endfunction

   function automatic logic [CODE_W-1:0] digit_char(input int unsigned d);
      return CH_ZERO + CODE_W'(d % 10);
   endfunction

   // Build the byte run of one value: command, sign, digits, unit pair, padding (large: command and sign)
   function automatic void predict_field(input logic [VALUE_W-1:0] raw, input logic celsius);
      logic        neg;
      int unsigned mag;
      int unsigned pad;
      neg = raw[VALUE_W-1];
      mag = neg ? 32'h10000 - 32'(raw) : 32'(raw);
      push_byte(cursor_cmd, 1'b1);
      push_byte(neg ? CH_MINUS : CH_BLANK, 1'b0);
      if (mag < LARGE_MAG) begin
         if (mag >= 1000) begin
            push_byte(digit_char(mag / 1000), 1'b0);
            push_byte(digit_char(mag / 100), 1'b0);
            push_byte(digit_char(mag / 10), 1'b0);
            pad = 1;
         end else if (mag >= 100) begin
            push_byte(digit_char(mag / 100), 1'b0);
            push_byte(digit_char(mag / 10), 1'b0);
            pad = 1;
         end else begin
            // below 1.0 this is the leading zero
            push_byte(digit_char(mag / 10), 1'b0);
            pad = 2;
         end
         push_byte(CH_POINT, 1'b0);
         push_byte(digit_char(mag), 1'b0);
         push_byte(celsius ? CH_DEGREE : CH_BLANK, 1'b0);
         push_byte(celsius ? CH_C : CH_BLANK, 1'b0);
         repeat (pad) push_byte(CH_BLANK, 1'b0);
      end
      field_bytes_q[field_bytes_q.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Track config, predict on accepted requests, check returned words
   always @(posedge clock) begin
      lcd_byte_type head;
      if (reset) begin
         field_bytes_q.delete();
         cursor_cmd = POS_CMD_RESET;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (field_bytes_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, actual code %0h cmd %0b last %0b",
                        $time, rsp_ch.char_code, rsp_ch.is_command, rsp_ch.last);
            end else begin
               head = field_bytes_q.pop_front();
               compare_field("char_code", head.code, rsp_ch.char_code);
               compare_field("is_command", head.cmd, rsp_ch.is_command);
               compare_field("last", head.last, rsp_ch.last);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            cursor_cmd = csr_ch.position_command;
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_field(req_ch.tenths_value, req_ch.celsius_unit);
         end
      end
      mismatch_total <= errors;
      bytes_owed     <= field_bytes_q.size();
   end

endmodule

/* sim/tb.sv */
module tb;
   import tlf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 16;
   localparam int PHASES       = 9;
   localparam int PHASE_VALUES = 50;

   logic clock;
   logic reset;
   int   mismatch_total;
   int   bytes_owed;
   int   quiet_cycles = 0;
   bit   req_gaps     = 1'b1;
   bit   rsp_stalls   = 1'b1;

   // Length classes, both signs, the most negative code and large magnitudes
   int corner_values [24] = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 32767,
                              -1, -9, -10, -99, -100, -999, -1000, -9999, -10000,
                              -32767, -32768, 12345, -4321};

   tlf_req_if req_ch ();
   tlf_rsp_if rsp_ch ();
   tlf_csr_if csr_ch ();

   tenths_value_to_lcd_field dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   lcd_field_checker field_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_total (mismatch_total),
      .bytes_owed     (bytes_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Send one value; hold valid high across back-to-back words
   task automatic send_value(input logic [VALUE_W-1:0] value, input logic celsius);
      int gap;
      gap = req_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.tenths_value <= value;
      req_ch.celsius_unit <= celsius;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Pick a length class, then a magnitude and sign within it
   task automatic send_random();
      int unsigned      mag;
      logic [VALUE_W-1:0] value;
      case ($urandom_range(0, 9))
         0:       mag = $urandom_range(0, 9);
         1:       mag = $urandom_range(10, 99);
         2, 3:    mag = $urandom_range(100, 999);
         4, 5, 6: mag = $urandom_range(1000, 9999);
         7:       mag = $urandom_range(10000, 32768);
         default: mag = 32'h10000 + $urandom_range(0, 16'hFFFF);
      endcase
      if (mag >= 32'h10000) begin
         value = VALUE_W'(mag);
      end else if ($urandom_range(0, 1) == 1) begin
         value = VALUE_W'(32'h10000 - mag);
      end else begin
         value = VALUE_W'(mag);
      end
      send_value(value, 1'($urandom_range(0, 1)));
   endtask

   // Drop valid and wait until every predicted word is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
   endtask

   task automatic write_cursor_cmd(input logic [CODE_W-1:0] cmd);
      csr_ch.valid            <= 1'b1;
      csr_ch.position_command <= cmd;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Result side: random stall before each word, sometimes none
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = rsp_stalls ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      logic [CODE_W-1:0] cmd;
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.tenths_value     = '0;
      req_ch.celsius_unit     = 1'b0;
      csr_ch.valid            = 1'b0;
      csr_ch.position_command = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_values[i]) begin
         send_value(VALUE_W'(corner_values[i]), 1'(i % 2));
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0:       cmd = 8'h00;
            1:       cmd = 8'hFF;
            2:       cmd = POS_CMD_RESET;
            3:       cmd = 8'hC0;
            default: cmd = CODE_W'($urandom_range(0, 255));
         endcase
         write_cursor_cmd(cmd);
         req_gaps   = (phase % 3) != 1;
         rsp_stalls = (phase % 4) != 2;
         repeat (PHASE_VALUES) send_random();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: end the run after a long stretch with no word moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
